// File: rtl/tcw_pkg.sv
// Shared constants, types and the character translation for the text cell writer.
package tcw_pkg;

   localparam int SCREEN_COLS = 40;
   localparam int SCREEN_ROWS = 25;
   localparam int OFFSET_W    = 10;
   localparam int PROD_W      = 16;

   localparam logic [1:0] MODE_ASCII = 2'd0;
   localparam logic [1:0] MODE_RAW_A = 2'd1;
   localparam logic [1:0] MODE_RAW_B = 2'd2;

   localparam logic [1:0] REG_FG_COLOUR    = 2'd0;
   localparam logic [1:0] REG_BG_COLOUR    = 2'd1;
   localparam logic [1:0] REG_CHARSET_MODE = 2'd2;

   localparam logic [7:0] CHAR_END     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CODE_NONE    = 8'h00;

   localparam logic [2:0] FG_RESET = 3'd7;
   localparam logic [2:0] BG_RESET = 3'd0;

   typedef struct packed {
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] margin;
   } cursor_type;

   typedef struct packed {
      logic                write_valid;
      logic [OFFSET_W-1:0] cell_offset;
      logic [7:0]          display_code;
      logic [7:0]          colour_byte;
   } cell_type;

   function automatic logic [7:0] translate_ascii(input logic [7:0] ch);
      logic [7:0] code;
      code = CODE_NONE;
      if (ch >= 8'h30 && ch <= 8'h39)      code = 8'(ch - 8'h10);
      else if (ch >= 8'h41 && ch <= 8'h5A) code = 8'(ch - 8'h40);
      else if (ch >= 8'h61 && ch <= 8'h7A) code = 8'(ch + 8'h20);
      else if (ch >= 8'h21 && ch <= 8'h2F) code = 8'(ch + 8'h40);
      else if (ch >= 8'h3A && ch <= 8'h3F) code = 8'(ch + 8'h36);
      return code;
   endfunction

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? 8'hFF : 8'(v + 8'd1);
   endfunction

endpackage

// File: rtl/tcw_cell_step.sv
// Per-character step: cursor update and cell write for one transfer.
module tcw_cell_step
   import tcw_pkg::*;
(
   input  logic [7:0] char_code,
   input  logic       start_of_text,
   input  logic [7:0] origin_x,
   input  logic [7:0] origin_y,
   input  logic [2:0] fg_colour,
   input  logic [2:0] bg_colour,
   input  logic [1:0] charset_mode,
   input  cursor_type cursor,
   output cursor_type cursor_next,
   output cell_type   cell_out
);

   cursor_type          base;
   logic                ignore;
   logic                newline;
   logic                on_screen;
   logic [PROD_W-1:0]   offset_full;
   logic [7:0]          code;
   logic [7:0]          colour;

   always_comb begin
      base.col    = start_of_text ? origin_x : cursor.col;
      base.row    = start_of_text ? origin_y : cursor.row;
      base.margin = start_of_text ? origin_x : cursor.margin;

      ignore  = (char_code == CHAR_END) ||
                !((charset_mode == MODE_ASCII) || (charset_mode == MODE_RAW_A) ||
                  (charset_mode == MODE_RAW_B));
      newline = (charset_mode == MODE_ASCII) && (char_code == CHAR_NEWLINE);

      code   = (charset_mode == MODE_ASCII) ? translate_ascii(char_code) : char_code;
      colour = {charset_mode == MODE_RAW_B, fg_colour, 1'b0, bg_colour};

      on_screen   = (32'(base.col) < SCREEN_COLS) && (32'(base.row) < SCREEN_ROWS);
      offset_full = PROD_W'(32'(base.row) * SCREEN_COLS + 32'(base.col));

      cursor_next = base;
      cell_out    = '0;
      if (!ignore) begin
         if (newline) begin
            cursor_next.row = sat_inc(base.row);
            cursor_next.col = base.margin;
         end else begin
            cursor_next.col = sat_inc(base.col);
            if (on_screen) begin
               cell_out.write_valid  = 1'b1;
               cell_out.cell_offset  = offset_full[OFFSET_W-1:0];
               cell_out.display_code = code;
               cell_out.colour_byte  = colour;
            end
         end
      end
   end

endmodule

// File: rtl/text_cell_writer_core.sv
// Text cell writer top level: registers, result buffering and APB register file.
// An accepted input transfer's result is held in the output register, or in the skid register while rsp is stalled.
// Throughput: one character per cycle while req_stall is low; a two-entry result buffer (output register
// plus skid register) lets one more input be accepted while rsp is stalled.
// Reset: synchronous; cursor, margin, buffer valid flags cleared, fg 7, bg 0, ascii mode.
module text_cell_writer_core
   import tcw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_char_code,
   input  logic                req_start_of_text,
   input  logic [7:0]          req_origin_x,
   input  logic [7:0]          req_origin_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_write_valid,
   output logic [OFFSET_W-1:0] rsp_cell_offset,
   output logic [7:0]          rsp_display_code,
   output logic [7:0]          rsp_colour_byte,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic [2:0] fg_ff;
   logic [2:0] bg_ff;
   logic [1:0] mode_ff;
   logic [1:0] reg_index;
   logic       cfg_write;

   cursor_type cursor_ff;
   cursor_type cursor_in;
   cell_type   cell_in;
   cell_type   out_ff;
   cell_type   skid_ff;
   logic       out_valid_ff;
   logic       skid_valid_ff;
   logic       req_take;
   logic       out_free;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      case (reg_index)
         REG_FG_COLOUR:    prdata = 32'(fg_ff);
         REG_BG_COLOUR:    prdata = 32'(bg_ff);
         REG_CHARSET_MODE: prdata = 32'(mode_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff   <= FG_RESET;
         bg_ff   <= BG_RESET;
         mode_ff <= MODE_ASCII;
      end else if (cfg_write) begin
         case (reg_index)
            REG_FG_COLOUR:    fg_ff   <= pwdata[2:0];
            REG_BG_COLOUR:    bg_ff   <= pwdata[2:0];
            REG_CHARSET_MODE: mode_ff <= pwdata[1:0];
            default:          ;
         endcase
      end
   end

   tcw_cell_step u_step (
      .char_code     (req_char_code),
      .start_of_text (req_start_of_text),
      .origin_x      (req_origin_x),
      .origin_y      (req_origin_y),
      .fg_colour     (fg_ff),
      .bg_colour     (bg_ff),
      .charset_mode  (mode_ff),
      .cursor        (cursor_ff),
      .cursor_next   (cursor_in),
      .cell_out      (cell_in)
   );

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff     <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            cursor_ff <= cursor_in;
         end
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= req_take;
            end
         end else if (req_take) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : cell_in;
      end else if (req_take) begin
         skid_ff <= cell_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_write_valid  = out_ff.write_valid;
   assign rsp_cell_offset  = out_ff.cell_offset;
   assign rsp_display_code = out_ff.display_code;
   assign rsp_colour_byte  = out_ff.colour_byte;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_offset_on_screen: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.write_valid) |->
         (32'(out_ff.cell_offset) < SCREEN_COLS * SCREEN_ROWS))
      else $error("cell offset beyond screen");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.write_valid) |->
         (out_ff.cell_offset == '0 && out_ff.display_code == '0 &&
          out_ff.colour_byte == '0))
      else $error("nonzero fields on a result without a write");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> !skid_valid_ff)
      else $error("skid entry not drained after output moved");

endmodule
